FILE: rtl/core/nsp_pkg.sv
// Package for the nested-scope cycle profiler: widths, codes and table entry type.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package nsp_pkg;

    localparam int unsigned ANCHORS_DEF    = 4096;
    localparam int unsigned NEST_DEPTH_DEF = 32;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned ANCHOR_W = 12;
    localparam int unsigned BYTES_W  = 32;
    localparam int unsigned CTR_W    = 64;
    localparam int unsigned STATUS_W = 2;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // one anchor table row
    typedef struct packed {
        logic [CTR_W-1:0] excl;
        logic [CTR_W-1:0] incl;
        logic [CTR_W-1:0] hits;
        logic [CTR_W-1:0] bytes;
    } tbl_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/nsp_req_if.sv
// Request channel of the profiler: valid/ready plus one event.
// Depends on nsp_pkg.
`default_nettype none

interface nsp_req_if;
    logic                          valid;
    logic                          ready;
    logic [nsp_pkg::FUNC_W-1:0]    func;
    logic [nsp_pkg::ANCHOR_W-1:0]  anchor;
    logic [nsp_pkg::BYTES_W-1:0]   byte_count;
    logic [nsp_pkg::CTR_W-1:0]     timestamp;

    modport source (output valid, func, anchor, byte_count, timestamp, input ready);
    modport sink   (input valid, func, anchor, byte_count, timestamp, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nsp_rsp_if.sv
// Response channel of the profiler: valid/ready plus status and four counters.
// Depends on nsp_pkg.
`default_nettype none

interface nsp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nsp_pkg::STATUS_W-1:0]  status;
    logic [nsp_pkg::CTR_W-1:0]     exclusive_time;
    logic [nsp_pkg::CTR_W-1:0]     inclusive_time;
    logic [nsp_pkg::CTR_W-1:0]     hit_total;
    logic [nsp_pkg::CTR_W-1:0]     byte_total;

    modport source (output valid, status, exclusive_time, inclusive_time, hit_total,
                    byte_total, input ready);
    modport sink   (input valid, status, exclusive_time, inclusive_time, hit_total,
                    byte_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module nsp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nested_scope_cycle_profiler.sv
// Nested-scope cycle profiler top level: anchor table, nesting stack, sequencer.
// Depends on nsp_pkg, nsp_req_if, nsp_rsp_if and nsp_ram.
//
// Usage:
//   req carries one event per transfer: func enter / exit / read, an anchor,
//   a byte count and the timer value. rsp returns one result per event:
//   status plus the anchor's four counters on a read (zeros otherwise).
//   Counters live in one RAM row per anchor; the nesting stack is a second RAM.
// Sequencing: a refused enter/exit or an unused code is answered from S_IDX;
//   enter and read go on through S_ENT or S_RD, exit through S_X1, S_X2, S_X3.
//   req takes the next transfer the cycle after rsp is loaded, so one item is
//   handled at a time. The exit's extra steps come from the table's one read
//   and one write port: read parent, write parent while reading the anchor,
//   write the anchor.
// Reset: control state clears at once; then a clearing pass zeroes the
//   anchor table, one row per cycle, with req.ready low.
// Stall: the result sits in an output register; a new req transfer is taken
//   while it waits. The next item finishes its work up to its result and
//   then holds, with its last table write, until rsp.ready frees the register.
`default_nettype none

module nested_scope_cycle_profiler #(
    parameter int unsigned ANCHORS    = nsp_pkg::ANCHORS_DEF,
    parameter int unsigned NEST_DEPTH = nsp_pkg::NEST_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nsp_req_if.sink     req,
    nsp_rsp_if.source   rsp
);

    localparam int unsigned CTR_W  = nsp_pkg::CTR_W;
    localparam int unsigned AIN_W  = nsp_pkg::ANCHOR_W;
    localparam int unsigned IDX_W  = $clog2(ANCHORS);
    localparam int unsigned SA_W   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(NEST_DEPTH + 1);
    localparam int unsigned SW     = 2 * IDX_W + 2 * CTR_W;
    localparam int unsigned TW     = $bits(nsp_pkg::tbl_entry_t);

    // anchor mod ANCHORS: q = (x * RECIP) >> 24 is low by at most one,
    // so one compare-subtract finishes it
    localparam int unsigned     RSH       = 24;
    localparam logic [RSH-1:0]  RECIP     = RSH'((64'd1 << RSH) / ANCHORS);
    localparam logic [16:0]     ANCHORS_C = 17'(ANCHORS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ANCHORS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NEST_DEPTH);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_IDX  = 8'b0000_0100,
        S_ENT  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_X1   = 8'b0010_0000,
        S_X2   = 8'b0100_0000,
        S_X3   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic [CNT_W-1:0]  nest_count_reg, nest_count_next;
    logic [IDX_W-1:0]  parent_reg, parent_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [nsp_pkg::FUNC_W-1:0]  func_reg;
    logic [AIN_W-1:0]            x_reg;
    logic [nsp_pkg::BYTES_W-1:0] bytes_reg;
    logic [CTR_W-1:0]            ts_reg;
    logic [AIN_W-1:0]            q_reg;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            p_reg, s_reg;
    logic [CTR_W-1:0]            old_reg, elapsed_reg, fwd_reg, fwd_next;
    logic [nsp_pkg::STATUS_W-1:0] status_reg;
    logic [CTR_W-1:0]            excl_reg, incl_reg, hits_reg, byte_tot_reg;

    // result load
    logic                         res_load;
    logic [nsp_pkg::STATUS_W-1:0] res_status;
    nsp_pkg::tbl_entry_t          res_cnt;
    logic                         slot_free;

    // index reduction
    logic [AIN_W+RSH-1:0] prod;
    logic [28:0]          qm;
    logic [AIN_W:0]       r_raw;
    logic [16:0]          r_ext, r_fix;
    logic [IDX_W-1:0]     idx_comb;

    // memories
    logic                 tbl_we, tbl_re;
    logic [IDX_W-1:0]     tbl_waddr, tbl_raddr;
    nsp_pkg::tbl_entry_t  tbl_wdata, tbl_rd;
    logic [TW-1:0]        tbl_rdata;
    logic                 stk_we, stk_re;
    logic [SA_W-1:0]      stk_waddr, stk_raddr;
    logic [SW-1:0]        stk_wdata, stk_rdata;

    // popped stack fields
    logic [CTR_W-1:0]     stk_start, stk_old;
    logic [IDX_W-1:0]     stk_anchor, stk_parent;
    logic [CTR_W-1:0]     excl_base;

    logic stack_full, stack_empty, req_fire;

    assign req_fire    = req.valid && req.ready;
    assign req.ready   = (state_reg == S_IDLE);
    assign slot_free   = !out_valid_reg || rsp.ready;
    assign stack_full  = (nest_count_reg == FULL_CNT);
    assign stack_empty = (nest_count_reg == '0);

    assign prod     = (AIN_W+RSH)'(req.anchor) * (AIN_W+RSH)'(RECIP);
    assign qm       = 29'(q_reg) * 29'(ANCHORS_C);
    assign r_raw    = {1'b0, x_reg} - qm[AIN_W:0];
    assign r_ext    = 17'(r_raw);
    assign r_fix    = (r_ext >= ANCHORS_C) ? (r_ext - ANCHORS_C) : r_ext;
    assign idx_comb = r_fix[IDX_W-1:0];

    assign tbl_rd     = nsp_pkg::tbl_entry_t'(tbl_rdata);
    assign stk_start  = stk_rdata[CTR_W-1:0];
    assign stk_old    = stk_rdata[2*CTR_W-1:CTR_W];
    assign stk_anchor = stk_rdata[2*CTR_W+IDX_W-1:2*CTR_W];
    assign stk_parent = stk_rdata[SW-1:2*CTR_W+IDX_W];

    // parent and anchor may be the same row: take the value just written
    assign excl_base = (s_reg == p_reg) ? fwd_reg : tbl_rd.excl;

    always_comb
    begin
        state_next      = state_reg;
        nest_count_next = nest_count_reg;
        parent_next     = parent_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        fwd_next        = fwd_reg;
        res_load        = 1'b0;
        res_status      = nsp_pkg::STAT_OK;
        res_cnt         = '0;
        tbl_we          = 1'b0;
        tbl_waddr       = idx_reg;
        tbl_wdata       = tbl_rd;
        tbl_re          = 1'b0;
        tbl_raddr       = idx_comb;
        stk_we          = 1'b0;
        stk_waddr       = SA_W'(nest_count_reg);
        stk_wdata       = {parent_reg, idx_reg, tbl_rd.incl, ts_reg};
        stk_re          = 1'b0;
        stk_raddr       = SA_W'(nest_count_reg - 1'b1);

        case (state_reg)
            S_CLR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                idx_next = idx_comb;
                case (func_reg)
                    nsp_pkg::FUNC_ENTER:
                    begin
                        if (stack_full)
                        begin
                            res_status = nsp_pkg::STAT_FULL;
                            if (slot_free)
                            begin
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            tbl_re     = 1'b1;
                            state_next = S_ENT;
                        end
                    end
                    nsp_pkg::FUNC_EXIT:
                    begin
                        if (stack_empty)
                        begin
                            res_status = nsp_pkg::STAT_EMPTY;
                            if (slot_free)
                            begin
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            stk_re     = 1'b1;
                            state_next = S_X1;
                        end
                    end
                    nsp_pkg::FUNC_READ:
                    begin
                        tbl_re     = 1'b1;
                        state_next = S_RD;
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_ENT:
            begin
                tbl_wdata.bytes = tbl_rd.bytes + CTR_W'(bytes_reg);
                if (slot_free)
                begin
                    tbl_we          = 1'b1;
                    stk_we          = 1'b1;
                    res_load        = 1'b1;
                    nest_count_next = nest_count_reg + 1'b1;
                    parent_next     = idx_reg;
                    state_next      = S_IDLE;
                end
            end
            S_RD:
            begin
                res_cnt = tbl_rd;
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_X1:
            begin
                // fetch the parent row
                tbl_re     = 1'b1;
                tbl_raddr  = stk_parent;
                state_next = S_X2;
            end
            S_X2:
            begin
                fwd_next       = tbl_rd.excl - elapsed_reg;
                tbl_we         = 1'b1;
                tbl_waddr      = p_reg;
                tbl_wdata.excl = fwd_next;
                tbl_re         = 1'b1;
                tbl_raddr      = s_reg;
                state_next     = S_X3;
            end
            S_X3:
            begin
                tbl_waddr      = s_reg;
                tbl_wdata.excl = excl_base + elapsed_reg;
                tbl_wdata.incl = old_reg + elapsed_reg;
                tbl_wdata.hits = tbl_rd.hits + 1'b1;
                if (slot_free)
                begin
                    tbl_we          = 1'b1;
                    res_load        = 1'b1;
                    nest_count_next = nest_count_reg - 1'b1;
                    parent_next     = p_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            nest_count_reg <= '0;
            parent_reg     <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nest_count_reg <= nest_count_next;
            parent_reg     <= parent_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg  <= req.func;
            x_reg     <= req.anchor;
            bytes_reg <= req.byte_count;
            ts_reg    <= req.timestamp;
            q_reg     <= prod[AIN_W+RSH-1:RSH];
        end
        idx_reg <= idx_next;
        fwd_reg <= fwd_next;
        if (state_reg == S_X1)
        begin
            p_reg       <= stk_parent;
            s_reg       <= stk_anchor;
            old_reg     <= stk_old;
            elapsed_reg <= ts_reg - stk_start;
        end
        if (res_load)
        begin
            status_reg   <= res_status;
            excl_reg     <= res_cnt.excl;
            incl_reg     <= res_cnt.incl;
            hits_reg     <= res_cnt.hits;
            byte_tot_reg <= res_cnt.bytes;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.exclusive_time = excl_reg;
    assign rsp.inclusive_time = incl_reg;
    assign rsp.hit_total      = hits_reg;
    assign rsp.byte_total     = byte_tot_reg;

    // anchor counter table, one row per anchor
    nsp_ram #(
        .WIDTH (TW),
        .DEPTH (ANCHORS)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // nesting stack: {parent, anchor, old inclusive, start}
    nsp_ram #(
        .WIDTH (SW),
        .DEPTH (NEST_DEPTH)
    ) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nest_count_reg <= FULL_CNT)
        else $error("nesting depth beyond stack size");

    a_exit_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_X3 && slot_free) |=>
            nest_count_reg == CNT_W'($past(nest_count_reg) - 1'b1))
        else $error("exit did not pop the stack");

    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != nsp_pkg::STAT_OK) |->
            (rsp.exclusive_time == '0 && rsp.inclusive_time == '0 &&
             rsp.hit_total == '0 && rsp.byte_total == '0))
        else $error("refused result carries counter data");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg != S_IDLE && state_reg != S_IDX))
        else $error("table written outside an update step");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_nested_scope_cycle_profiler.sv
`timescale 1ns / 1ps
// Self-checking testbench for nested_scope_cycle_profiler: directed table, then random traffic.
// Depends on nsp_pkg, nsp_req_if, nsp_rsp_if and the profiler RTL; a local model predicts results.

module tb_nested_scope_cycle_profiler;

    localparam int unsigned FUNC_W   = nsp_pkg::FUNC_W;
    localparam int unsigned ANCHOR_W = nsp_pkg::ANCHOR_W;
    localparam int unsigned BYTES_W  = nsp_pkg::BYTES_W;
    localparam int unsigned CTR_W    = nsp_pkg::CTR_W;
    localparam int unsigned STATUS_W = nsp_pkg::STATUS_W;

    localparam int unsigned ANCHORS      = nsp_pkg::ANCHORS_DEF;
    localparam int unsigned NEST_DEPTH   = nsp_pkg::NEST_DEPTH_DEF;
    localparam logic [ANCHOR_W-1:0] LAST_ANCHOR = ANCHOR_W'(ANCHORS - 1);
    // the one func code with no defined operation
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned MAX_IDLE     = 16;
    // leave a margin after the last result
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned DRAIN_EVERY   = 400;

    // one result as the block returns it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CTR_W-1:0]    excl;
        logic [CTR_W-1:0]    incl;
        logic [CTR_W-1:0]    hits;
        logic [CTR_W-1:0]    byte_sum;
    } profile_result_t;

    // one row of the directed table; reps > 1 repeats the row, spread fills in payload
    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [ANCHOR_W-1:0] idx;
        logic [BYTES_W-1:0]  nbytes;
        logic [CTR_W-1:0]    stamp;
        int unsigned         reps;
        bit                  spread;
        bit                  typed;
        logic [STATUS_W-1:0] typed_status;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    nsp_req_if req_ch ();
    nsp_rsp_if rsp_ch ();

    nested_scope_cycle_profiler #(
        .ANCHORS    (ANCHORS),
        .NEST_DEPTH (NEST_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Behavioral copy of the anchor table and nesting stack
    // ------------------------------------------------------------------
    logic [CTR_W-1:0]    scope_excl     [ANCHORS];
    logic [CTR_W-1:0]    scope_incl     [ANCHORS];
    logic [CTR_W-1:0]    scope_hits     [ANCHORS];
    logic [CTR_W-1:0]    scope_bytes    [ANCHORS];
    logic [ANCHOR_W-1:0] frame_parent   [NEST_DEPTH];
    logic [ANCHOR_W-1:0] frame_anchor   [NEST_DEPTH];
    logic [CTR_W-1:0]    frame_old_incl [NEST_DEPTH];
    logic [CTR_W-1:0]    frame_start    [NEST_DEPTH];
    int unsigned         open_scopes;
    logic [ANCHOR_W-1:0] parent_anchor;

    // results still owed by the block, oldest first
    profile_result_t pending_results[$];

    // typed expectation that travels with the request payload
    bit                  row_typed;
    logic [STATUS_W-1:0] row_typed_status;

    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned enter_count, exit_count, read_count, full_count, empty_count, deepest;

    // stimulus-side state
    logic [CTR_W-1:0] timer_now;
    int unsigned      sent_depth;
    bit               send_quiet, recv_quiet;

    // Applies one event to the model and returns the result it owes.
    function automatic profile_result_t profile_event(input logic [FUNC_W-1:0]   op,
                                                      input logic [ANCHOR_W-1:0] idx,
                                                      input logic [BYTES_W-1:0]  nbytes,
                                                      input logic [CTR_W-1:0]    stamp);
        profile_result_t     r;
        int unsigned         slot;
        int unsigned         top;
        logic [ANCHOR_W-1:0] p;
        logic [ANCHOR_W-1:0] s;
        logic [CTR_W-1:0]    elapsed;
        r    = '0;
        slot = idx % ANCHORS;
        case (op)
            nsp_pkg::FUNC_ENTER:
                if (open_scopes >= NEST_DEPTH)
                begin
                    r.status = nsp_pkg::STAT_FULL;
                end
                else
                begin
                    top                 = open_scopes;
                    scope_bytes[slot]   = scope_bytes[slot] + nbytes;
                    frame_parent[top]   = parent_anchor;
                    frame_anchor[top]   = ANCHOR_W'(slot);
                    frame_old_incl[top] = scope_incl[slot];
                    frame_start[top]    = stamp;
                    open_scopes         = top + 1;
                    parent_anchor       = ANCHOR_W'(slot);
                end
            nsp_pkg::FUNC_EXIT:
                if (open_scopes == 0)
                begin
                    r.status = nsp_pkg::STAT_EMPTY;
                end
                else
                begin
                    top           = open_scopes - 1;
                    p             = frame_parent[top];
                    s             = frame_anchor[top];
                    elapsed       = stamp - frame_start[top];
                    // parent first, then the anchor: matters when both are the same row
                    scope_excl[p] = scope_excl[p] - elapsed;
                    scope_excl[s] = scope_excl[s] + elapsed;
                    scope_incl[s] = frame_old_incl[top] + elapsed;
                    scope_hits[s] = scope_hits[s] + 1;
                    parent_anchor = p;
                    open_scopes   = top;
                end
            nsp_pkg::FUNC_READ:
            begin
                r.excl     = scope_excl[slot];
                r.incl     = scope_incl[slot];
                r.hits     = scope_hits[slot];
                r.byte_sum = scope_bytes[slot];
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Anchor choice: mostly a small working set so reads see accumulated counts.
    function automatic logic [ANCHOR_W-1:0] pick_anchor();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return ANCHOR_W'($urandom_range(0, 15));
        else if (r < 80)
            return LAST_ANCHOR;
        else if (r < 90)
            return '0;
        else
            return ANCHOR_W'($urandom);
    endfunction

    // Timer for the next event: usually a forward step, sometimes near the wrap point
    // or a jump anywhere.
    function automatic logic [CTR_W-1:0] next_stamp();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 90)
            timer_now = timer_now + $urandom_range(0, 2000);
        else if (r < 95)
            timer_now = {CTR_W{1'b1}} - $urandom_range(0, 3000);
        else
            timer_now = {$urandom, $urandom};
        return timer_now;
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return {BYTES_W{1'b1}};
        else
            return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transfer per call, with idle gap and optional drain
    // ------------------------------------------------------------------
    task automatic drive_item(input logic [FUNC_W-1:0]   op,
                              input logic [ANCHOR_W-1:0] idx,
                              input logic [BYTES_W-1:0]  nbytes,
                              input logic [CTR_W-1:0]    stamp,
                              input bit                  typed,
                              input logic [STATUS_W-1:0] typed_status,
                              input bit                  drain);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 99) < 3)
            send_quiet = !send_quiet;
        // valid only drops when the line really goes idle; back-to-back keeps it high
        if (drain || gap != 0)
            req_ch.valid <= 1'b0;
        if (drain)
        begin
            // hold off until the block has returned everything it owes
            do
                @(posedge clk);
            while (pending_results.size() != 0);
        end
        repeat (gap) @(posedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= op;
        req_ch.anchor     <= idx;
        req_ch.byte_count <= nbytes;
        req_ch.timestamp  <= stamp;
        row_typed         <= typed;
        row_typed_status  <= typed_status;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        // keep a private nesting count so the random part can steer depth
        if (op == nsp_pkg::FUNC_ENTER && sent_depth < NEST_DEPTH)
            sent_depth++;
        else if (op == nsp_pkg::FUNC_EXIT && sent_depth > 0)
            sent_depth--;
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls per result, with stretches of none
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        recv_quiet = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 99) < 3)
                recv_quiet = !recv_quiet;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: check returned results, then predict accepted requests.
    // Values are sampled at the edge, before any update of that edge lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        profile_result_t want;
        profile_result_t pred;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: status %0d", rsp_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.exclusive_time !== want.excl)
                    begin
                        $error("exclusive_time: expected %h, got %h",
                               want.excl, rsp_ch.exclusive_time);
                        fail_count++;
                    end
                    if (rsp_ch.inclusive_time !== want.incl)
                    begin
                        $error("inclusive_time: expected %h, got %h",
                               want.incl, rsp_ch.inclusive_time);
                        fail_count++;
                    end
                    if (rsp_ch.hit_total !== want.hits)
                    begin
                        $error("hit_total: expected %h, got %h", want.hits, rsp_ch.hit_total);
                        fail_count++;
                    end
                    if (rsp_ch.byte_total !== want.byte_sum)
                    begin
                        $error("byte_total: expected %h, got %h",
                               want.byte_sum, rsp_ch.byte_total);
                        fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                // the model always advances; a typed row overrides what is checked
                pred = profile_event(req_ch.func, req_ch.anchor, req_ch.byte_count,
                                     req_ch.timestamp);
                if (row_typed)
                begin
                    want        = '0;
                    want.status = row_typed_status;
                end
                else
                begin
                    want = pred;
                end
                pending_results.push_back(want);
                if (pred.status == nsp_pkg::STAT_FULL)
                    full_count++;
                else if (pred.status == nsp_pkg::STAT_EMPTY)
                    empty_count++;
                else if (req_ch.func == nsp_pkg::FUNC_ENTER)
                    enter_count++;
                else if (req_ch.func == nsp_pkg::FUNC_EXIT)
                    exit_count++;
                else if (req_ch.func == nsp_pkg::FUNC_READ)
                    read_count++;
                if (open_scopes > deepest)
                    deepest = open_scopes;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    stim_row_t directed[$];

    task automatic add_row(input logic [FUNC_W-1:0]   op,
                           input logic [ANCHOR_W-1:0] idx,
                           input logic [BYTES_W-1:0]  nbytes,
                           input logic [CTR_W-1:0]    stamp,
                           input int unsigned         reps,
                           input bit                  spread,
                           input bit                  typed,
                           input logic [STATUS_W-1:0] typed_status);
        stim_row_t row;
        row.op           = op;
        row.idx          = idx;
        row.nbytes       = nbytes;
        row.stamp        = stamp;
        row.reps         = reps;
        row.spread       = spread;
        row.typed        = typed;
        row.typed_status = typed_status;
        directed.push_back(row);
    endtask

    initial
    begin
        int unsigned         depth_goal;
        int unsigned         pick;
        logic [FUNC_W-1:0]   op;
        logic [ANCHOR_W-1:0] idx;
        logic [BYTES_W-1:0]  nbytes;
        logic [CTR_W-1:0]    stamp;

        // every block input known from time zero; reset held low
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= nsp_pkg::FUNC_READ;
        req_ch.anchor     <= '0;
        req_ch.byte_count <= '0;
        req_ch.timestamp  <= '0;
        row_typed         <= 1'b0;
        row_typed_status  <= nsp_pkg::STAT_OK;

        for (int i = 0; i < ANCHORS; i++)
        begin
            scope_excl[i]  = '0;
            scope_incl[i]  = '0;
            scope_hits[i]  = '0;
            scope_bytes[i] = '0;
        end
        for (int i = 0; i < NEST_DEPTH; i++)
        begin
            frame_parent[i]   = '0;
            frame_anchor[i]   = '0;
            frame_old_incl[i] = '0;
            frame_start[i]    = '0;
        end
        open_scopes   = 0;
        parent_anchor = '0;
        fail_count    = 0;
        checked_count = 0;
        enter_count   = 0;
        exit_count    = 0;
        read_count    = 0;
        full_count    = 0;
        empty_count   = 0;
        deepest       = 0;
        timer_now     = 64'h1000;
        sent_depth    = 0;
        send_quiet    = 1'b0;

        // Directed table. Typed rows are those readable at a glance: cleared table,
        // refusals, the unused code. The rest go through the model.
        add_row(nsp_pkg::FUNC_READ, '0, '0, '0, 1, 0, 1, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_READ, LAST_ANCHOR, '0, '0, 1, 0, 1, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, '0, 1, 0, 1, nsp_pkg::STAT_EMPTY);
        add_row(FUNC_UNUSED, LAST_ANCHOR, {BYTES_W{1'b1}}, {CTR_W{1'b1}},
                1, 0, 1, nsp_pkg::STAT_OK);
        // two nested scopes that straddle the timer wrap
        add_row(nsp_pkg::FUNC_ENTER, LAST_ANCHOR, {BYTES_W{1'b1}}, 64'hFFFF_FFFF_FFFF_FFF0,
                1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_ENTER, 12'd1, '0, 64'hFFFF_FFFF_FFFF_FFF8,
                1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, 64'h10, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, 64'h20, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_READ, LAST_ANCHOR, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_READ, 12'd1, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        // root exclusive has gone below zero and wraps
        add_row(nsp_pkg::FUNC_READ, '0, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        // second max byte count carries into the upper half of the total
        add_row(nsp_pkg::FUNC_ENTER, LAST_ANCHOR, {BYTES_W{1'b1}}, 64'h100,
                1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_ENTER, '0, '0, '0, NEST_DEPTH - 1, 1, 0, nsp_pkg::STAT_OK);
        // stack full: refused, nothing changes
        add_row(nsp_pkg::FUNC_ENTER, 12'd7, {BYTES_W{1'b1}}, '0, 1, 0, 1, nsp_pkg::STAT_FULL);
        add_row(FUNC_UNUSED, 12'd7, '0, '0, 1, 0, 1, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_READ, 12'd7, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, '0, NEST_DEPTH, 1, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, '0, 1, 0, 1, nsp_pkg::STAT_EMPTY);
        add_row(nsp_pkg::FUNC_READ, LAST_ANCHOR, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        // the root entering itself, then an exit over the full timer range
        add_row(nsp_pkg::FUNC_ENTER, '0, 12345, '0, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_EXIT, '0, '0, {CTR_W{1'b1}}, 1, 0, 0, nsp_pkg::STAT_OK);
        add_row(nsp_pkg::FUNC_READ, '0, '0, '0, 1, 0, 0, nsp_pkg::STAT_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ready stays low through the clearing pass; the handshake absorbs it
        foreach (directed[r])
        begin
            for (int k = 0; k < directed[r].reps; k++)
            begin
                if (directed[r].spread)
                    drive_item(directed[r].op, ANCHOR_W'($urandom_range(0, 15)), $urandom,
                               next_stamp(), directed[r].typed, directed[r].typed_status,
                               1'b0);
                else
                    drive_item(directed[r].op, directed[r].idx, directed[r].nbytes,
                               directed[r].stamp, directed[r].typed,
                               directed[r].typed_status, 1'b0);
            end
        end

        // Random part: mostly depth-steered enter/exit with reads mixed in,
        // plus a little noise over every field and func code.
        depth_goal = $urandom_range(0, NEST_DEPTH + 1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 3)
                depth_goal = $urandom_range(0, NEST_DEPTH + 1);
            pick   = $urandom_range(0, 99);
            idx    = pick_anchor();
            nbytes = pick_bytes();
            stamp  = next_stamp();
            if (pick < 6)
            begin
                op     = FUNC_W'($urandom_range(0, 3));
                idx    = ANCHOR_W'($urandom);
                nbytes = $urandom;
                stamp  = {$urandom, $urandom};
            end
            else if (pick < 30)
                op = nsp_pkg::FUNC_READ;
            else if (sent_depth < depth_goal)
                op = nsp_pkg::FUNC_ENTER;
            else if (sent_depth > depth_goal)
                op = nsp_pkg::FUNC_EXIT;
            else
                op = $urandom_range(0, 1) ? nsp_pkg::FUNC_ENTER : nsp_pkg::FUNC_EXIT;
            // a goal past the stack size or at zero hits the refusals
            drive_item(op, idx, nbytes, stamp, 1'b0, nsp_pkg::STAT_OK,
                       (n % DRAIN_EVERY) == 0);
        end
        req_ch.valid <= 1'b0;

        // step past the last accepting edge so its prediction is queued first
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d enters, %0d exits, %0d reads, nesting up to %0d.",
                 checked_count, enter_count, exit_count, read_count, deepest);
        $display("Refusals seen: %0d on a full stack, %0d on an empty one; %0d mismatches.",
                 full_count, empty_count, fail_count);
        if (fail_count == 0)
            $display("nested_scope_cycle_profiler test passed");
        else
            $display("nested_scope_cycle_profiler test failed");
        $finish;
    end

    // watchdog: far beyond the slowest correct run, clearing pass included
    initial
    begin
        #10_000_000;
        $display("nested_scope_cycle_profiler test failed");
        $finish;
    end

endmodule
